// File: src/plcr_pkg.sv
// Shared types, constants and state encoding for the piecewise-linear color ramp.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package plcr_pkg;

    // Table size and fraction precision.
    localparam int MAX_BREAKPOINTS = 8;
    localparam int FRACTION_BITS   = 12;

    // Derived widths.
    localparam int ADDR_W  = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
    localparam int CNT_W   = $clog2(MAX_BREAKPOINTS + 1);
    localparam int P_W     = FRACTION_BITS + 1;
    localparam int KEY_W   = 16;
    localparam int CHAN_W  = 8;
    localparam int EIDX_W  = 3;
    localparam int CFG_W   = 4;

    // Fraction value that stands for 1.0.
    localparam logic [P_W-1:0] FRAC_ONE = P_W'(1) << FRACTION_BITS;

    // Command codes.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        rgb_t                    colour;
    } entry_t;

    // Input request payload.
    typedef struct packed {
        logic                    command;
        logic [EIDX_W-1:0]       entry_index;
        logic signed [KEY_W-1:0] entry_key;
        logic [CHAN_W-1:0]       entry_red;
        logic [CHAN_W-1:0]       entry_green;
        logic [CHAN_W-1:0]       entry_blue;
        logic signed [KEY_W-1:0] lookup_value;
    } plcr_in_t;

    // Result payload.
    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
    } plcr_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_BLEND,
        ST_OUT
    } plcr_state_t;

endpackage

`default_nettype wire

// File: src/piecewise_linear_color_ramp_unit.sv
// Top level of the piecewise-linear color ramp: sequencer, table, divider, blender.
// Depends on plcr_pkg, plcr_table, plcr_divider and plcr_blend.
//
// Usage:
//   The s_ channel carries requests of type plcr_in_t. A write request
//   (command zero) stores one breakpoint and gives no result.
//   A lookup request gives one plcr_out_t color on the m_ channel.
//   cfg_we/cfg_wdata set the number of breakpoints in use; write it only while
//   the block is idle. Zero counts as one and values above the table size
//   count as the table size.
//   The scan reads one entry a cycle from the table's single read port; an
//   interpolated lookup then runs the bit-serial divider (one fraction bit a
//   cycle) and the shared blend multiplier (one channel a cycle). One request
//   is in flight at a time; s_ready is low while a lookup runs.
//   A finished color sits in an output register; the next request is taken
//   while it waits, but a further lookup holds before delivery until the
//   receiver raises m_ready. Reset restores a count of one, all keys zero,
//   entry zero blue and the other colors black.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_color_ramp_unit (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire plcr_pkg::plcr_in_t    s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output plcr_pkg::plcr_out_t        m_data,
    input  wire logic                  cfg_we,
    input  wire logic [plcr_pkg::CFG_W-1:0] cfg_wdata
);
    import plcr_pkg::*;

    plcr_state_t             state_reg, state_next;
    logic [CFG_W-1:0]        count_reg;
    logic [CNT_W-1:0]        n_eff;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [ADDR_W-1:0]       idx_reg, idx_next;
    logic signed [KEY_W-1:0] value_reg, value_next;
    logic signed [KEY_W-1:0] k0_reg, k0_next;
    rgb_t                    c0_reg, c0_next;
    rgb_t                    c1_reg, c1_next;
    rgb_t                    res_reg, res_next;
    logic                    m_valid_reg;
    plcr_out_t               m_data_reg;

    logic                    accept;
    logic                    tbl_wr_en;
    entry_t                  tbl_wr_entry;
    logic [ADDR_W-1:0]       rd_addr;
    entry_t                  rd_entry;
    logic                    div_start;
    logic [KEY_W-1:0]        div_num, div_den;
    logic                    div_done;
    logic [P_W-1:0]          div_quot;
    logic                    blend_start;
    logic                    blend_done;
    rgb_t                    blend_rgb;
    logic                    out_load;
    logic                    value_above;
    logic [KEY_W:0]          num_wide, den_wide;

    // Breakpoint count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CFG_W'(1);
        end else if (cfg_we) begin
            count_reg <= cfg_wdata;
        end
    end

    // Count in use, clamped to one .. table size.
    always_comb begin
        if (count_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(count_reg) > MAX_BREAKPOINTS) begin
            n_eff = CNT_W'(MAX_BREAKPOINTS);
        end else begin
            n_eff = CNT_W'(count_reg);
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Table write path; indexes beyond the table are dropped.
    assign tbl_wr_en = accept && (s_data.command == CMD_WRITE)
                       && ({{(32 - EIDX_W){1'b0}}, s_data.entry_index}
                           < 32'(MAX_BREAKPOINTS));
    assign tbl_wr_entry.key          = s_data.entry_key;
    assign tbl_wr_entry.colour.red   = s_data.entry_red;
    assign tbl_wr_entry.colour.green = s_data.entry_green;
    assign tbl_wr_entry.colour.blue  = s_data.entry_blue;

    plcr_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (tbl_wr_en),
        .wr_addr  (ADDR_W'(s_data.entry_index)),
        .wr_entry (tbl_wr_entry),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    // Operands for the fraction: both differences are positive and fit 16 bits.
    assign value_above = value_reg > rd_entry.key;
    assign num_wide    = (KEY_W+1)'($signed({value_reg[KEY_W-1], value_reg})
                                    - $signed({k0_reg[KEY_W-1], k0_reg}));
    assign den_wide    = (KEY_W+1)'($signed({rd_entry.key[KEY_W-1], rd_entry.key})
                                    - $signed({k0_reg[KEY_W-1], k0_reg}));
    assign div_num     = num_wide[KEY_W-1:0];
    assign div_den     = den_wide[KEY_W-1:0];

    plcr_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    plcr_blend u_blend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (blend_start),
        .frac    (div_quot),
        .c0      (c0_reg),
        .c1      (c1_reg),
        .done    (blend_done),
        .result  (blend_rgb)
    );

    // Sequencer: scan, divide, blend, deliver.
    always_comb begin
        state_next  = state_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        value_next  = value_reg;
        k0_next     = k0_reg;
        c0_next     = c0_reg;
        c1_next     = c1_reg;
        res_next    = res_reg;
        rd_addr     = idx_reg;
        div_start   = 1'b0;
        blend_start = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_data.command == CMD_LOOKUP)) begin
                    value_next = s_data.lookup_value;
                    n_next     = n_eff;
                    idx_next   = '0;
                    rd_addr    = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!value_above) begin
                    if (idx_reg == '0) begin
                        // At or below the first key: first color.
                        res_next   = rd_entry.colour;
                        state_next = ST_OUT;
                    end else begin
                        c1_next    = rd_entry.colour;
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end else begin
                    k0_next = rd_entry.key;
                    c0_next = rd_entry.colour;
                    if (CNT_W'(idx_reg) + CNT_W'(1) == n_reg) begin
                        // Above the last key in use: last color.
                        res_next   = rd_entry.colour;
                        state_next = ST_OUT;
                    end else begin
                        idx_next = idx_reg + ADDR_W'(1);
                        rd_addr  = idx_reg + ADDR_W'(1);
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    blend_start = 1'b1;
                    state_next  = ST_BLEND;
                end
            end
            ST_BLEND: begin
                if (blend_done) begin
                    res_next   = blend_rgb;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        value_reg <= value_next;
        k0_reg    <= k0_next;
        c0_reg    <= c0_next;
        c1_reg    <= c1_next;
        res_reg   <= res_next;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.out_red   <= res_reg.red;
            m_data_reg.out_green <= res_reg.green;
            m_data_reg.out_blue  <= res_reg.blue;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide state");

    // The blender only finishes while the sequencer waits for it.
    a_blend_done_in_blend: assert property (@(posedge aclk) disable iff (!aresetn)
        blend_done |-> state_reg == ST_BLEND)
        else $error("blender finished outside blend state");

    // A division is started only with a positive divisor no smaller than the dividend.
    a_div_den_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> div_den != '0 && div_num <= div_den)
        else $error("bad divider operands");

    // The scan never reads past the entries in use.
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> CNT_W'(idx_reg) < n_reg)
        else $error("scan index past count");

endmodule

`default_nettype wire

// File: src/plcr_table.sv
// Breakpoint table: one write port and one registered read port.
// Depends on plcr_pkg for the entry type and table size.
`timescale 1ns / 1ps
`default_nettype none

module plcr_table (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   wr_en,
    input  wire logic [plcr_pkg::ADDR_W-1:0] wr_addr,
    input  wire plcr_pkg::entry_t       wr_entry,
    input  wire logic [plcr_pkg::ADDR_W-1:0] rd_addr,
    output plcr_pkg::entry_t            rd_entry
);
    import plcr_pkg::*;

    entry_t entries_reg [MAX_BREAKPOINTS];
    entry_t rd_entry_reg;

    // Table storage; reset leaves entry zero blue and all others zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg[0] <= '{key: '0, colour: '{red: '0, green: '0, blue: '1}};
            for (int i = 1; i < MAX_BREAKPOINTS; i++) begin
                entries_reg[i] <= '0;
            end
        end else if (wr_en) begin
            entries_reg[wr_addr] <= wr_entry;
        end
    end

    // Registered read.
    always_ff @(posedge aclk) begin
        rd_entry_reg <= entries_reg[rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

// File: src/plcr_divider.sv
// Bit-serial restoring divider producing floor((num << FRACTION_BITS) / den).
// Requires num <= den and den > 0. Depends on plcr_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module plcr_divider (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [plcr_pkg::KEY_W-1:0]  num,
    input  wire logic [plcr_pkg::KEY_W-1:0]  den,
    output logic                             done,
    output logic [plcr_pkg::P_W-1:0]         quot
);
    import plcr_pkg::*;

    localparam int STEP_W = $clog2(P_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [KEY_W-1:0]  rem_reg, rem_next;
    logic [KEY_W-1:0]  den_reg, den_next;
    logic [P_W-1:0]    quot_reg, quot_next;
    logic [KEY_W:0]    trial;
    logic              fits;

    // One quotient bit per cycle; the first step is taken without a shift.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        trial     = (step_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        fits      = trial >= {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = num;
            den_next  = den;
            quot_next = '0;
        end else if (busy_reg) begin
            rem_next  = fits ? KEY_W'(trial - {1'b0, den_reg}) : KEY_W'(trial);
            quot_next = {quot_reg[P_W-2:0], fits};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(P_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

    // The remainder never reaches the divisor after a step.
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !start |=> rem_reg < den_reg || !busy_reg || $past(start))
        else $error("divider remainder not reduced");

    // A finished quotient never exceeds one.
    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> quot_reg <= FRAC_ONE)
        else $error("divider quotient above one");

    // Done is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("divider done held");

endmodule

`default_nettype wire

// File: src/plcr_blend.sv
// Color blender: one shared multiplier computes c0 + floor(p * (c1 - c0) / 2^F)
// for red, green and blue in turn. Depends on plcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plcr_blend (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [plcr_pkg::P_W-1:0] frac,
    input  wire plcr_pkg::rgb_t       c0,
    input  wire plcr_pkg::rgb_t       c1,
    output logic                      done,
    output plcr_pkg::rgb_t            result
);
    import plcr_pkg::*;

    localparam int DIFF_W = CHAN_W + 1;
    localparam int PROD_W = P_W + 1 + DIFF_W;

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [1:0]                chan_reg, chan_next;
    logic [P_W-1:0]            frac_reg, frac_next;
    rgb_t                      c0_reg, c0_next;
    rgb_t                      c1_reg, c1_next;
    rgb_t                      res_reg, res_next;
    logic [CHAN_W-1:0]         a, b;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  scaled;
    logic [CHAN_W-1:0]         mixed;

    // Pick the channel in work and run it through the multiplier.
    always_comb begin
        case (chan_reg)
            2'd0: begin
                a = c0_reg.red;
                b = c1_reg.red;
            end
            2'd1: begin
                a = c0_reg.green;
                b = c1_reg.green;
            end
            default: begin
                a = c0_reg.blue;
                b = c1_reg.blue;
            end
        endcase
        diff   = $signed({1'b0, b}) - $signed({1'b0, a});
        prod   = $signed({1'b0, frac_reg}) * diff;
        scaled = prod >>> FRACTION_BITS;
        mixed  = a + scaled[CHAN_W-1:0];
    end

    // Sequencer over the three channels.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        chan_next = chan_reg;
        frac_next = frac_reg;
        c0_next   = c0_reg;
        c1_next   = c1_reg;
        res_next  = res_reg;
        if (start) begin
            busy_next = 1'b1;
            chan_next = 2'd0;
            frac_next = frac;
            c0_next   = c0;
            c1_next   = c1;
        end else if (busy_reg) begin
            case (chan_reg)
                2'd0:    res_next.red   = mixed;
                2'd1:    res_next.green = mixed;
                default: res_next.blue  = mixed;
            endcase
            chan_next = chan_reg + 2'd1;
            if (chan_reg == 2'd2) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            chan_reg <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            chan_reg <= chan_next;
        end
    end

    always_ff @(posedge aclk) begin
        frac_reg <= frac_next;
        c0_reg   <= c0_next;
        c1_reg   <= c1_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire
